### hw/rtl/pis_pkg.sv
// Shared types, constants and codes of the priority inheriting semaphore.
package pis_pkg;

    localparam int MaxHoldersDefault     = 8;
    localparam int WaitDepthDefault      = 16;
    localparam int PriorityLevelsDefault = 16;

    localparam logic signed [4:0] CountMax   = 5'sd15;
    localparam logic signed [4:0] CountReset = 5'sd1;

    typedef enum logic [2:0] {
        EV_GRANTED  = 3'd0,
        EV_BLOCKED  = 3'd1,
        EV_BOOSTED  = 3'd2,
        EV_WOKEN    = 3'd3,
        EV_RESTORED = 3'd4,
        EV_FAIL     = 3'd5,
        EV_WAITFULL = 3'd6
    } event_kind_t;

    typedef enum logic [0:0] {
        REQ_TAKE = 1'b0,
        REQ_GIVE = 1'b1
    } req_type_t;

    typedef enum logic [0:0] {
        REG_INITIAL_COUNT  = 1'b0,
        REG_INHERIT_ENABLE = 1'b1
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_BOOST,
        ST_TAKE_END,
        ST_FIND,
        ST_WAKE_SCAN,
        ST_WAKE_EMIT,
        ST_WAKE_SHIFT,
        ST_RESTORE,
        ST_HOLD_SHIFT
    } state_t;

    // Controller -> datapath commands
    typedef struct packed {
        logic latch_req;
        logic clr_idx;
        logic inc_idx;
        logic idx_best;
        logic idx_found;
        logic set_best;
        logic grant;
        logic give_neg;
        logic boost;
        logic append_wait;
        logic shift_wait;
        logic pop_wait;
        logic restore;
        logic shift_hold;
        logic pop_hold;
        logic emit;
        logic last;
        event_kind_t kind;
        logic [1:0] src;   // 0 request, 1 holder at idx, 2 best waiter, 3 found holder
    } pis_cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic is_give;
        logic count_pos;
        logic count_neg;
        logic hold_full;
        logic wait_full;
        logic wait_empty;
        logic inherit;
        logic idx_in_hold;
        logic idx_in_wait;
        logic idx_shift_hold;
        logic idx_shift_wait;
        logic hold_match;
        logic hold_boost;
        logic wait_better;
    } pis_stat_t;

endpackage

### hw/rtl/pis_ctrl.sv
// Sequencer for take and give requests.
module pis_ctrl
    import pis_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  pis_stat_t stat,
    output pis_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                priority if (!stat.is_give)
                begin
                    if (stat.count_pos)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = stat.inherit ? ST_BOOST : ST_TAKE_END;
                    end
                end
                else if (stat.count_neg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_FIND;
                end
            end
            ST_BOOST:
            begin
                if (!stat.idx_in_hold)
                begin
                    state_next = ST_TAKE_END;
                end
            end
            ST_TAKE_END:
            begin
                state_next = ST_IDLE;
            end
            ST_FIND:
            begin
                priority if (!stat.idx_in_hold)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.hold_match)
                begin
                    state_next = stat.wait_empty ? ST_RESTORE : ST_WAKE_SCAN;
                end
            end
            ST_WAKE_SCAN:
            begin
                if (!stat.idx_in_wait)
                begin
                    state_next = ST_WAKE_EMIT;
                end
            end
            ST_WAKE_EMIT:
            begin
                state_next = ST_WAKE_SHIFT;
            end
            ST_WAKE_SHIFT:
            begin
                if (!stat.idx_shift_wait)
                begin
                    state_next = ST_RESTORE;
                end
            end
            ST_RESTORE:
            begin
                state_next = ST_HOLD_SHIFT;
            end
            ST_HOLD_SHIFT:
            begin
                if (!stat.idx_shift_hold)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != ST_IDLE);
        cmd.kind = EV_FAIL;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.latch_req = start;
            end
            ST_DECIDE:
            begin
                cmd.clr_idx = 1'b1;
                priority if (!stat.is_give)
                begin
                    if (stat.count_pos)
                    begin
                        cmd.emit = 1'b1;
                        cmd.last = 1'b1;
                        cmd.kind = stat.hold_full ? EV_FAIL : EV_GRANTED;
                        cmd.grant = !stat.hold_full;
                    end
                end
                else if (stat.count_neg)
                begin
                    cmd.emit     = 1'b1;
                    cmd.last     = 1'b1;
                    cmd.kind     = EV_GRANTED;
                    cmd.give_neg = 1'b1;
                end
            end
            ST_BOOST:
            begin
                if (stat.idx_in_hold)
                begin
                    cmd.inc_idx = 1'b1;
                    if (stat.hold_boost)
                    begin
                        cmd.boost = 1'b1;
                        cmd.emit  = 1'b1;
                        cmd.kind  = EV_BOOSTED;
                        cmd.src   = 2'd1;
                    end
                end
            end
            ST_TAKE_END:
            begin
                cmd.emit = 1'b1;
                cmd.last = 1'b1;
                cmd.kind = stat.wait_full ? EV_WAITFULL : EV_BLOCKED;
                cmd.append_wait = !stat.wait_full;
            end
            ST_FIND:
            begin
                priority if (!stat.idx_in_hold)
                begin
                    cmd.emit = 1'b1;
                    cmd.last = 1'b1;
                    cmd.kind = EV_FAIL;
                end
                else if (stat.hold_match)
                begin
                    cmd.clr_idx = 1'b1;
                end
                else
                begin
                    cmd.inc_idx = 1'b1;
                end
            end
            ST_WAKE_SCAN:
            begin
                if (stat.idx_in_wait)
                begin
                    cmd.inc_idx  = 1'b1;
                    cmd.set_best = stat.wait_better;
                end
            end
            ST_WAKE_EMIT:
            begin
                cmd.emit     = 1'b1;
                cmd.kind     = EV_WOKEN;
                cmd.src      = 2'd2;
                cmd.idx_best = 1'b1;
            end
            ST_WAKE_SHIFT:
            begin
                if (stat.idx_shift_wait)
                begin
                    cmd.shift_wait = 1'b1;
                    cmd.inc_idx    = 1'b1;
                end
                else
                begin
                    cmd.pop_wait = 1'b1;
                end
            end
            ST_RESTORE:
            begin
                cmd.emit      = 1'b1;
                cmd.last      = 1'b1;
                cmd.kind      = EV_RESTORED;
                cmd.src       = 2'd3;
                cmd.restore   = 1'b1;
                cmd.idx_found = 1'b1;
            end
            ST_HOLD_SHIFT:
            begin
                if (stat.idx_shift_hold)
                begin
                    cmd.shift_hold = 1'b1;
                    cmd.inc_idx    = 1'b1;
                end
                else
                begin
                    cmd.pop_hold = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

### hw/rtl/pis_dp.sv
// Holder and wait lists, counters, scan index and result register.
module pis_dp
    import pis_pkg::*;
#(
    parameter int MAX_HOLDERS     = MaxHoldersDefault,
    parameter int WAIT_DEPTH      = WaitDepthDefault,
    parameter int PRIORITY_LEVELS = PriorityLevelsDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_type,
    input  logic [7:0]  task_id,
    input  logic [3:0]  task_priority,
    input  logic        cfg_count_wr,
    input  logic signed [4:0] initial_count,
    input  logic        inherit_enable,
    input  pis_cmd_t    cmd,
    output pis_stat_t   stat,
    output logic        event_valid,
    output logic [2:0]  event_kind,
    output logic [7:0]  event_task,
    output logic [3:0]  event_priority,
    output logic        last_event
);

    localparam int HW = $clog2(MAX_HOLDERS + 1);
    localparam int WW = $clog2(WAIT_DEPTH + 1);
    localparam int IW = (HW > WW) ? HW : WW;
    localparam int HA = (MAX_HOLDERS > 1) ? $clog2(MAX_HOLDERS) : 1;
    localparam int WA = $clog2(WAIT_DEPTH);
    localparam logic [3:0] PrioTop = (PRIORITY_LEVELS > 16) ? 4'd15
                                                            : 4'(PRIORITY_LEVELS - 1);

    logic [7:0] hid_reg   [MAX_HOLDERS];
    logic [3:0] horig_reg [MAX_HOLDERS];
    logic [3:0] hcur_reg  [MAX_HOLDERS];
    logic [7:0] wid_reg   [WAIT_DEPTH];
    logic [3:0] wpri_reg  [WAIT_DEPTH];

    logic [HW-1:0] hused_reg;
    logic [WW-1:0] wlen_reg;
    logic signed [4:0] count_reg;
    logic [IW-1:0] idx_reg;
    logic [HA-1:0] found_reg;
    logic [WA-1:0] best_reg;
    logic          rtype_reg;
    logic [7:0]    rid_reg;
    logic [3:0]    rpri_reg;

    logic        ev_valid_reg;
    logic [2:0]  ev_kind_reg;
    logic [7:0]  ev_task_reg;
    logic [3:0]  ev_pri_reg;
    logic        ev_last_reg;

    logic [HA-1:0] hidx;
    logic [WA-1:0] widx;
    logic [HA-1:0] hidx1;
    logic [WA-1:0] widx1;
    logic [HA-1:0] hused_a;
    logic [WA-1:0] wlen_a;
    logic [3:0]    pri_clamped;

    assign hidx    = HA'(idx_reg);
    assign widx    = WA'(idx_reg);
    assign hidx1   = HA'(idx_reg + IW'(1));
    assign widx1   = WA'(idx_reg + IW'(1));
    assign hused_a = HA'(hused_reg);
    assign wlen_a  = WA'(wlen_reg);
    assign pri_clamped = (task_priority > PrioTop) ? PrioTop : task_priority;

    always_comb
    begin
        stat.is_give        = (rtype_reg == REQ_GIVE);
        stat.count_pos      = (count_reg > 5'sd0);
        stat.count_neg      = (count_reg < 5'sd0);
        stat.hold_full      = (hused_reg >= HW'(MAX_HOLDERS));
        stat.wait_full      = (wlen_reg >= WW'(WAIT_DEPTH));
        stat.wait_empty     = (wlen_reg == '0);
        stat.inherit        = inherit_enable;
        stat.idx_in_hold    = (IW'(idx_reg) < IW'(hused_reg));
        stat.idx_in_wait    = (IW'(idx_reg) < IW'(wlen_reg));
        stat.idx_shift_hold = (IW'(idx_reg) + IW'(1) < IW'(hused_reg));
        stat.idx_shift_wait = (IW'(idx_reg) + IW'(1) < IW'(wlen_reg));
        stat.hold_match     = (hid_reg[hidx] == rid_reg);
        stat.hold_boost     = (rpri_reg < hcur_reg[hidx]);
        stat.wait_better    = (idx_reg == '0) || (wpri_reg[widx] < wpri_reg[best_reg]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hused_reg    <= '0;
            wlen_reg     <= '0;
            count_reg    <= CountReset;
            ev_valid_reg <= 1'b0;
        end
        else
        begin
            ev_valid_reg <= cmd.emit;
            if (cfg_count_wr)
            begin
                count_reg <= initial_count;
                hused_reg <= '0;
                wlen_reg  <= '0;
            end
            else
            begin
                if (cmd.grant)
                begin
                    hused_reg <= hused_reg + HW'(1);
                    count_reg <= count_reg - 5'sd1;
                end
                if (cmd.append_wait)
                begin
                    wlen_reg <= wlen_reg + WW'(1);
                end
                if (cmd.pop_wait)
                begin
                    wlen_reg <= wlen_reg - WW'(1);
                end
                if (cmd.pop_hold)
                begin
                    hused_reg <= hused_reg - HW'(1);
                end
                if ((cmd.give_neg || cmd.pop_hold) && count_reg < CountMax)
                begin
                    count_reg <= count_reg + 5'sd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_req)
        begin
            rtype_reg <= req_type;
            rid_reg   <= task_id;
            rpri_reg  <= pri_clamped;
        end
        if (cmd.clr_idx)
        begin
            idx_reg <= '0;
            if (stat.is_give && stat.hold_match)
            begin
                found_reg <= hidx;
            end
        end
        else if (cmd.idx_best)
        begin
            idx_reg <= IW'(best_reg);
        end
        else if (cmd.idx_found)
        begin
            idx_reg <= IW'(found_reg);
        end
        else if (cmd.inc_idx)
        begin
            idx_reg <= idx_reg + IW'(1);
        end
        if (cmd.set_best)
        begin
            best_reg <= widx;
        end
        if (cmd.grant)
        begin
            hid_reg[hused_a]   <= rid_reg;
            horig_reg[hused_a] <= rpri_reg;
            hcur_reg[hused_a]  <= rpri_reg;
        end
        if (cmd.boost)
        begin
            hcur_reg[hidx] <= rpri_reg;
        end
        if (cmd.append_wait)
        begin
            wid_reg[wlen_a]  <= rid_reg;
            wpri_reg[wlen_a] <= rpri_reg;
        end
        if (cmd.shift_wait)
        begin
            wid_reg[widx]  <= wid_reg[widx1];
            wpri_reg[widx] <= wpri_reg[widx1];
        end
        if (cmd.restore)
        begin
            hcur_reg[found_reg] <= horig_reg[found_reg];
        end
        if (cmd.shift_hold)
        begin
            hid_reg[hidx]   <= hid_reg[hidx1];
            horig_reg[hidx] <= horig_reg[hidx1];
            hcur_reg[hidx]  <= hcur_reg[hidx1];
        end
        if (cmd.emit)
        begin
            ev_kind_reg <= cmd.kind;
            ev_last_reg <= cmd.last;
            unique case (cmd.src)
                2'd1:
                begin
                    ev_task_reg <= hid_reg[hidx];
                    ev_pri_reg  <= rpri_reg;
                end
                2'd2:
                begin
                    ev_task_reg <= wid_reg[best_reg];
                    ev_pri_reg  <= wpri_reg[best_reg];
                end
                2'd3:
                begin
                    ev_task_reg <= hid_reg[found_reg];
                    ev_pri_reg  <= horig_reg[found_reg];
                end
                default:
                begin
                    ev_task_reg <= rid_reg;
                    ev_pri_reg  <= rpri_reg;
                end
            endcase
        end
    end

    // Restore shifting starts at the found slot
    assign event_valid    = ev_valid_reg;
    assign event_kind     = ev_kind_reg;
    assign event_task     = ev_task_reg;
    assign event_priority = ev_pri_reg;
    assign last_event     = ev_last_reg;

endmodule

### hw/rtl/priority_inheriting_semaphore.sv
// Top level of the priority inheriting semaphore.
// Sequencing: a take decided at once, or a give at a negative count, strobes its one result
//   from the decide state; a blocked take strobes its last result after the holder boost
//   scan, if inheritance is on; a give that finds its holder wakes the best waiter, if any,
//   before its final restore result. One request at a time; a give may keep busy high
//   while it shifts the holder list after its final result. The receiver cannot stall.
// Reset: count loads 1, inheritance on, both lists empty; no clearing pass.
module priority_inheriting_semaphore
    import pis_pkg::*;
#(
    parameter int MAX_HOLDERS     = MaxHoldersDefault,
    parameter int WAIT_DEPTH      = WaitDepthDefault,
    parameter int PRIORITY_LEVELS = PriorityLevelsDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        start,
    output logic        busy,
    input  logic        req_type,
    input  logic [7:0]  task_id,
    input  logic [3:0]  task_priority,
    // result channel
    output logic        event_valid,
    output logic [2:0]  event_kind,
    output logic [7:0]  event_task,
    output logic [3:0]  event_priority,
    output logic        last_event,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic signed [4:0] init_count_reg;
    logic              inherit_reg;
    logic              wr_en;
    logic              count_wr;
    logic              reg_sel;
    pis_cmd_t          cmd;
    pis_stat_t         stat;

    // Register index comes from the word address; a transfer completes on the access cycle.
    assign pready   = 1'b1;
    assign reg_sel  = paddr[2];
    assign wr_en    = psel && penable && pwrite && (paddr[1:0] == 2'b00);
    assign count_wr = wr_en && (reg_sel == REG_INITIAL_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_count_reg <= CountReset;
            inherit_reg    <= 1'b1;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_INITIAL_COUNT:  init_count_reg <= signed'(pwdata[4:0]);
                REG_INHERIT_ENABLE: inherit_reg    <= pwdata[0];
                default:            inherit_reg    <= inherit_reg;
            endcase
        end
    end

    // Read back the register at the addressed word
    always_comb
    begin
        unique case (reg_sel)
            REG_INITIAL_COUNT:  prdata = {{27{init_count_reg[4]}}, init_count_reg};
            REG_INHERIT_ENABLE: prdata = {31'd0, inherit_reg};
            default:            prdata = '0;
        endcase
    end

    pis_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // Writing the starting count reloads the live count and empties both lists
    pis_dp #(
        .MAX_HOLDERS     (MAX_HOLDERS),
        .WAIT_DEPTH      (WAIT_DEPTH),
        .PRIORITY_LEVELS (PRIORITY_LEVELS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_type       (req_type),
        .task_id        (task_id),
        .task_priority  (task_priority),
        .cfg_count_wr   (count_wr),
        .initial_count  (signed'(pwdata[4:0])),
        .inherit_enable (inherit_reg),
        .cmd            (cmd),
        .stat           (stat),
        .event_valid    (event_valid),
        .event_kind     (event_kind),
        .event_task     (event_task),
        .event_priority (event_priority),
        .last_event     (last_event)
    );

endmodule

### hw/rtl/pis_checker.sv
// Port-level checks of the priority inheriting semaphore, bound to the top level.
module pis_checker
    import pis_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       event_valid,
    input logic [2:0] event_kind,
    input logic       last_event
);

    // A result only appears while a request is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        event_valid |-> $past(busy))
        else $error("result strobe without active request");

    // An accepted request makes the block busy next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    // Once the block is idle, only the final result of a request can still show
    assert property (@(posedge clk) disable iff (!rst_n)
        (event_valid && !busy) |-> last_event)
        else $error("intermediate result after release");

    // Boost and woken results are never final
    assert property (@(posedge clk) disable iff (!rst_n)
        (event_valid && (event_kind == EV_BOOSTED || event_kind == EV_WOKEN)) |-> !last_event)
        else $error("intermediate result marked last");

endmodule

bind priority_inheriting_semaphore pis_checker u_pis_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .event_valid (event_valid),
    .event_kind  (event_kind),
    .last_event  (last_event)
);

### tb/pis_scoreboard.sv
// Scoreboard class: semaphore predictor and expected-event store.
`timescale 1ns / 100ps

import pis_pkg::*;

class pis_scoreboard;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] tsk;
        logic [3:0] prio;
        logic       last;
    } sem_event_t;

    logic signed [4:0] init_count;
    bit                inherit_on;
    int                count;
    logic [7:0]        hold_id[8];
    logic [3:0]        hold_orig[8];
    logic [3:0]        hold_cur[8];
    int                hold_n;
    logic [7:0]        wait_id[16];
    logic [3:0]        wait_prio[16];
    int                wait_n;
    sem_event_t        pending[$];
    int                errors;

    function new();
        init_count = CountReset;
        inherit_on = 1;
        errors = 0;
        reload();
    endfunction

    function void reload();
        count = init_count;
        hold_n = 0;
        wait_n = 0;
    endfunction

    function void set_reg(reg_index_t idx, logic [31:0] val);
        if (idx == REG_INITIAL_COUNT)
        begin
            init_count = val[4:0];
            reload();
        end
        else
            inherit_on = val[0];
    endfunction

    function void push_event(event_kind_t k, logic [7:0] t, logic [3:0] p);
        sem_event_t e;
        e.kind = k;
        e.tsk = t;
        e.prio = p;
        e.last = 0;
        pending.push_back(e);
    endfunction

    // Note one accepted request and queue the events it causes.
    function void note_request(req_type_t rt, logic [7:0] id, logic [3:0] prio);
        int         g;
        int         best;
        sem_event_t e;
        if (rt == REQ_TAKE)
        begin
            if (count > 0)
            begin
                if (hold_n >= 8)
                    push_event(EV_FAIL, id, prio);
                else
                begin
                    hold_id[hold_n] = id;
                    hold_orig[hold_n] = prio;
                    hold_cur[hold_n] = prio;
                    hold_n++;
                    count--;
                    push_event(EV_GRANTED, id, prio);
                end
            end
            else
            begin
                if (inherit_on)
                    for (int i = 0; i < hold_n; i++)
                        if (prio < hold_cur[i])
                        begin
                            hold_cur[i] = prio;
                            push_event(EV_BOOSTED, hold_id[i], prio);
                        end
                if (wait_n >= 16)
                    push_event(EV_WAITFULL, id, prio);
                else
                begin
                    wait_id[wait_n] = id;
                    wait_prio[wait_n] = prio;
                    wait_n++;
                    push_event(EV_BLOCKED, id, prio);
                end
            end
        end
        else if (count < 0)
        begin
            count++;
            push_event(EV_GRANTED, id, prio);
        end
        else
        begin
            g = -1;
            for (int i = 0; i < hold_n; i++)
                if (g < 0 && hold_id[i] == id)
                    g = i;
            if (g < 0)
                push_event(EV_FAIL, id, prio);
            else
            begin
                if (wait_n > 0)
                begin
                    best = 0;
                    for (int i = 1; i < wait_n; i++)
                        if (wait_prio[i] < wait_prio[best])
                            best = i;
                    push_event(EV_WOKEN, wait_id[best], wait_prio[best]);
                    for (int i = best; i + 1 < wait_n; i++)
                    begin
                        wait_id[i] = wait_id[i + 1];
                        wait_prio[i] = wait_prio[i + 1];
                    end
                    wait_n--;
                end
                push_event(EV_RESTORED, hold_id[g], hold_orig[g]);
                for (int i = g; i + 1 < hold_n; i++)
                begin
                    hold_id[i] = hold_id[i + 1];
                    hold_orig[i] = hold_orig[i + 1];
                    hold_cur[i] = hold_cur[i + 1];
                end
                hold_n--;
                if (count < CountMax)
                    count++;
            end
        end
        e = pending.pop_back();
        e.last = 1;
        pending.push_back(e);
    endfunction

    // Compare one observed event with the oldest expectation.
    function void check_event(sem_event_t got);
        sem_event_t exp_ev;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected event, expected none, actual %h", $time, got);
            errors++;
            return;
        end
        exp_ev = pending.pop_front();
        if (got.kind !== exp_ev.kind)
        begin
            $display("%0t: event_kind expected %0d actual %0d", $time, exp_ev.kind, got.kind);
            errors++;
        end
        if (got.tsk !== exp_ev.tsk)
        begin
            $display("%0t: event_task expected %0d actual %0d", $time, exp_ev.tsk, got.tsk);
            errors++;
        end
        if (got.prio !== exp_ev.prio)
        begin
            $display("%0t: event_priority expected %0d actual %0d", $time, exp_ev.prio,
                     got.prio);
            errors++;
        end
        if (got.last !== exp_ev.last)
        begin
            $display("%0t: last_event expected %0d actual %0d", $time, exp_ev.last, got.last);
            errors++;
        end
    endfunction
endclass

### tb/priority_inheriting_semaphore_test.sv
// Top-level testbench of the priority inheriting semaphore.
`timescale 1ns / 100ps

module priority_inheriting_semaphore_test;
    import pis_pkg::*;

    localparam int WatchdogLimit = 5000;
    localparam int DrainCycles   = 60;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        req_type;
    logic [7:0]  task_id;
    logic [3:0]  task_priority;
    logic        event_valid;
    logic [2:0]  event_kind;
    logic [7:0]  event_task;
    logic [3:0]  event_priority;
    logic        last_event;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    pis_scoreboard sem_model;
    int            idle_cycles = 0;
    logic [7:0]    held_ids[$];

    priority_inheriting_semaphore i_dut (.*);

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // Check every strobed event and count cycles with no event and no request transfer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (event_valid)
                sem_model.check_event({event_kind, event_task, event_priority, last_event});
            if (event_valid || (start && !busy))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WatchdogLimit)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Write one register through a setup and an access phase.
    task automatic write_reg(reg_index_t idx, logic [31:0] val);
        @(negedge clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= 3'(4 * idx);
        pwdata <= val;
        @(negedge clk);
        penable <= 1;
        @(posedge clk);
        sem_model.set_reg(idx, val);
        @(negedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        held_ids.delete();
    endtask

    // Hold one request until it transfers, then note it with the predictor.
    task automatic send_request(req_type_t rt, logic [7:0] id, logic [3:0] prio, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 7) : 0;
        @(negedge clk);
        repeat (gap) @(negedge clk);
        start <= 1;
        req_type <= rt;
        task_id <= id;
        task_priority <= prio;
        do
            @(posedge clk);
        while (busy);
        sem_model.note_request(rt, id, prio);
        if (rt == REQ_TAKE)
            held_ids.push_back(id);
        @(negedge clk);
        start <= 0;
    endtask

    // Drain: wait for every expected event and for busy to fall, then for DrainCycles cycles.
    task automatic wait_quiet();
        while (sem_model.pending.size() != 0 || busy)
            @(negedge clk);
        repeat (DrainCycles) @(negedge clk);
    endtask

    // Pick a random request, mostly a well-formed take or a give by a known task.
    task automatic random_request(bit gaps);
        int         sel;
        logic [7:0] id;
        sel = $urandom_range(0, 9);
        if (sel < 5 || held_ids.size() == 0)
            send_request(REQ_TAKE, 8'($urandom_range(0, 15) * 17), 4'($urandom), gaps);
        else if (sel < 9)
        begin
            id = held_ids[$urandom_range(0, held_ids.size() - 1)];
            send_request(REQ_GIVE, id, 4'($urandom), gaps);
        end
        else
            send_request(REQ_GIVE, 8'($urandom), 4'($urandom), gaps);
    endtask

    initial
    begin
        sem_model = new();
        rst_n = 0;
        start = 0;
        req_type = 0;
        task_id = 0;
        task_priority = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        repeat (7) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: one grant, a boost, give paths, full holder list via high count, negative count, full wait list.
        send_request(REQ_TAKE, 8'd0, 4'd15, 0);
        send_request(REQ_TAKE, 8'd255, 4'd0, 0);
        send_request(REQ_TAKE, 8'd7, 4'd3, 0);
        send_request(REQ_GIVE, 8'd0, 4'd15, 0);
        send_request(REQ_GIVE, 8'd0, 4'd15, 0);
        send_request(REQ_GIVE, 8'd255, 4'd0, 0);
        send_request(REQ_GIVE, 8'd7, 4'd3, 0);
        wait_quiet();
        write_reg(REG_INITIAL_COUNT, 32'd15);
        for (int i = 0; i < 9; i++)
            send_request(REQ_TAKE, 8'(i), 4'(15 - i), 0);
        send_request(REQ_GIVE, 8'd3, 4'd0, 0);
        wait_quiet();
        write_reg(REG_INITIAL_COUNT, 32'h10);
        send_request(REQ_GIVE, 8'd170, 4'd5, 0);
        send_request(REQ_TAKE, 8'd85, 4'd10, 0);
        wait_quiet();
        write_reg(REG_INITIAL_COUNT, 32'd0);
        write_reg(REG_INHERIT_ENABLE, 32'd0);
        for (int i = 0; i < 17; i++)
            send_request(REQ_TAKE, 8'(i + 16), 4'($urandom), 0);
        wait_quiet();

        // Random phases across count and inheritance settings.
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(REG_INITIAL_COUNT, 32'($urandom_range(0, 31)));
            write_reg(REG_INHERIT_ENABLE, 32'(ph % 2 == 0));
            for (int n = 0; n < 65; n++)
                random_request(ph != 3);
            wait_quiet();
        end

        if (sem_model.errors == 0 && sem_model.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

### filelist.f
hw/rtl/pis_pkg.sv
hw/rtl/pis_ctrl.sv
hw/rtl/pis_dp.sv
hw/rtl/priority_inheriting_semaphore.sv
hw/rtl/pis_checker.sv
tb/pis_scoreboard.sv
tb/priority_inheriting_semaphore_test.sv
